FILE: sv/length_prefixed_deframer_assert.svh
// Assertion macros shared by the deframer modules.
// Each macro takes a label, the clock, the active-low reset, the checked terms and a message.
`ifndef LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH

// Check an invariant at every clock edge outside reset.
`define LPD_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define LPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its trigger.
`define LPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/lpd_pkg.sv
`default_nettype none

package lpd_pkg;

	// Result item codes
	typedef enum logic [2:0] {
		KIND_BYTE  = 3'd0,
		KIND_GOOD  = 3'd1,
		KIND_ZERO  = 3'd2,
		KIND_EMPTY = 3'd3,
		KIND_PROTO = 3'd4,
		KIND_OVER  = 3'd5
	} kind_t;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_FIRST  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_SECOND = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD  = 2'd2;

	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_DATA_W-1:0] MAX_PAYLOAD_RESET = 32'd65536;

	// Result queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
	} item_t;

	// One item offered across a module boundary
	typedef struct packed {
		logic  valid;
		item_t item;
	} item_slot_t;

endpackage

`default_nettype wire

FILE: sv/lpd_front.sv
`default_nettype none

module lpd_front
	import lpd_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   accept,
	input  wire logic [7:0]             byte_in,
	input  wire logic                   wr_en,
	input  wire logic [CFG_INDEX_W-1:0] wr_index,
	input  wire logic [CFG_DATA_W-1:0]  wr_data,
	output item_slot_t                  push
);

`include "length_prefixed_deframer_assert.svh"

	typedef enum logic [3:0] {
		PH_HEADER  = 4'b0001,
		PH_PAYLOAD = 4'b0010,
		PH_SKIP    = 4'b0100,
		PH_DEAD    = 4'b1000
	} phase_t;

	localparam logic [2:0] MAGIC_BYTES = 3'd2;
	localparam logic [2:0] HDR_LAST    = 3'd5;

	logic [7:0]             magic_first_q;
	logic [7:0]             magic_second_q;
	logic [CFG_DATA_W-1:0]  max_payload_q;

	phase_t                 phase_q, phase_d;
	logic [2:0]             hdr_cnt_q, hdr_cnt_d;
	logic [15:0]            magic_q, magic_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic [LENGTH_BITS-1:0] remaining_q, remaining_d;
	logic                   zero_seen_q, zero_seen_d;

	logic [LENGTH_BITS+7:0] len_cat;
	logic [LENGTH_BITS-1:0] len_next;
	logic [CFG_DATA_W-1:0]  len_ext;
	logic [LENGTH_BITS-1:0] rem_dec;
	logic                   zero_now;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_first_q  <= '0;
			magic_second_q <= '0;
			max_payload_q  <= MAX_PAYLOAD_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_MAGIC_FIRST:  magic_first_q  <= wr_data[7:0];
				CFG_MAGIC_SECOND: magic_second_q <= wr_data[7:0];
				CFG_MAX_PAYLOAD:  max_payload_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// Length with the new byte shifted in, upper bits dropped
	assign len_cat  = {len_q, byte_in};
	assign len_next = len_cat[LENGTH_BITS-1:0];
	assign len_ext  = CFG_DATA_W'(len_next);
	assign rem_dec  = remaining_q - {{(LENGTH_BITS-1){1'b0}}, |remaining_q};
	assign zero_now = (byte_in == 8'h00);

	// Classify the accepted byte and advance the framing state
	always_comb begin
		phase_d     = phase_q;
		hdr_cnt_d   = hdr_cnt_q;
		magic_d     = magic_q;
		len_d       = len_q;
		remaining_d = remaining_q;
		zero_seen_d = zero_seen_q;
		push        = '{valid: 1'b0, item: '{kind: KIND_BYTE, data_byte: 8'h00}};
		if (accept) begin
			case (phase_q)
				PH_HEADER: begin
					if (hdr_cnt_q < MAGIC_BYTES) begin
						magic_d = {magic_q[7:0], byte_in};
					end else begin
						len_d = len_next;
					end
					if (hdr_cnt_q == HDR_LAST) begin
						hdr_cnt_d = '0;
						if (magic_q != {magic_first_q, magic_second_q}) begin
							phase_d         = PH_DEAD;
							push.valid      = 1'b1;
							push.item.kind  = KIND_PROTO;
						end else begin
							remaining_d = len_next;
							len_d       = '0;
							magic_d     = '0;
							zero_seen_d = 1'b0;
							if (len_ext >= max_payload_q) begin
								phase_d        = (len_next != '0) ? PH_SKIP : PH_HEADER;
								push.valid     = 1'b1;
								push.item.kind = KIND_OVER;
							end else if (len_next == '0) begin
								push.valid     = 1'b1;
								push.item.kind = KIND_EMPTY;
							end else begin
								phase_d = PH_PAYLOAD;
							end
						end
					end else begin
						hdr_cnt_d = hdr_cnt_q + 3'd1;
					end
				end
				PH_SKIP: begin
					remaining_d = rem_dec;
					if (rem_dec == '0) begin
						phase_d = PH_HEADER;
					end
				end
				PH_PAYLOAD: begin
					remaining_d         = rem_dec;
					push.valid          = 1'b1;
					push.item.data_byte = byte_in;
					if (rem_dec != '0) begin
						zero_seen_d    = zero_seen_q | zero_now;
						push.item.kind = KIND_BYTE;
					end else begin
						phase_d        = PH_HEADER;
						zero_seen_d    = 1'b0;
						push.item.kind = (zero_seen_q | zero_now) ? KIND_ZERO : KIND_GOOD;
					end
				end
				PH_DEAD: ;
				default: phase_d = PH_HEADER;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hdr_cnt_q   <= '0;
			magic_q     <= '0;
			len_q       <= '0;
			remaining_q <= '0;
			zero_seen_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			hdr_cnt_q   <= hdr_cnt_d;
			magic_q     <= magic_d;
			len_q       <= len_d;
			remaining_q <= remaining_d;
			zero_seen_q <= zero_seen_d;
		end
	end

	`LPD_ASSERT_NEXT(a_dead_sticks, clk, arst_n, phase_q == PH_DEAD, phase_q == PH_DEAD, "dead phase left")
	`LPD_ASSERT_IMPL(a_payload_nonzero, clk, arst_n, phase_q == PH_PAYLOAD, remaining_q != '0, "payload with nothing left")
	`LPD_ASSERT_IMPL(a_skip_nonzero, clk, arst_n, phase_q == PH_SKIP, remaining_q != '0, "skip with nothing left")
	`LPD_ASSERT_ALWAYS(a_hdr_count, clk, arst_n, hdr_cnt_q <= HDR_LAST, "header count overran")

endmodule

`default_nettype wire

FILE: sv/lpd_queue.sv
`default_nettype none

module lpd_queue
	import lpd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  item_slot_t push,
	input  wire logic pop,
	output item_slot_t head,
	output logic      full
);

`include "length_prefixed_deframer_assert.svh"

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.item  = entry_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + {{QPTR_W{1'b0}}, push.valid} - {{QPTR_W{1'b0}}, pop};
		end
	end

	`LPD_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= (QPTR_W+1)'(QUEUE_DEPTH), "queue count overran")
	`LPD_ASSERT_IMPL(a_no_overflow, clk, arst_n, push.valid, !full, "push into full queue")
	`LPD_ASSERT_IMPL(a_no_underflow, clk, arst_n, pop, head.valid, "pop from empty queue")

endmodule

`default_nettype wire

FILE: sv/lpd_back.sv
`default_nettype none

module lpd_back
	import lpd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  item_slot_t      head,
	output logic            pop,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [2:0]      kind,
	output logic [7:0]      data_byte
);

	logic  out_valid_q;
	item_t out_item_q;

	// Refill the output register when it is empty or being taken
	assign pop = head.valid && (!out_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold payload while stalled
	always_ff @(posedge clk) begin
		if (pop) begin
			out_item_q <= head.item;
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = out_item_q.kind;
	assign data_byte    = out_item_q.data_byte;

endmodule

`default_nettype wire

FILE: sv/length_prefixed_deframer.sv
// Length-prefixed stream deframer.
// Byte channel: byte_valid, byte_stall, byte_in; one raw stream byte per item.
// Result channel: result_valid, result_stall, kind, data_byte; zero or one
// result item per accepted byte (payload bytes, final-byte verdicts, empty
// message, bad magic, oversize).
// Configuration: wr_en, wr_index, wr_data write magic_first (0), magic_second
// (1) and max_payload (2); write only while the block is idle.
// Throughput: one byte per cycle while byte_stall is low. A front stage
// classifies each byte in the cycle it is accepted and pushes its result
// into a four-entry queue; an output register drains the queue. A result
// passes through the queue and then the output register before it appears
// on the result port.
// byte_stall is high while the queue is full, which happens only when the
// receiver holds result_stall; a stalled result holds its value.
// Reset (arst_n, asynchronous, active low) restores the register defaults
// (magics 0, max_payload 65536), returns to header parsing and empties the
// queue and output register. After bad magic every byte is taken and dropped
// until reset.
`default_nettype none

module length_prefixed_deframer
	import lpd_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   byte_valid,
	output logic                        byte_stall,
	input  wire logic [7:0]             byte_in,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output logic [2:0]                  kind,
	output logic [7:0]                  data_byte,
	input  wire logic                   wr_en,
	input  wire logic [CFG_INDEX_W-1:0] wr_index,
	input  wire logic [CFG_DATA_W-1:0]  wr_data
);

	item_slot_t push;
	item_slot_t head;
	logic       pop;
	logic       q_full;
	logic       accept;

	assign byte_stall = q_full;
	assign accept     = byte_valid && !q_full;

	lpd_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.byte_in (byte_in),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.push    (push)
	);

	lpd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.full  (q_full)
	);

	lpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind        (kind),
		.data_byte   (data_byte)
	);

endmodule

`default_nettype wire

FILE: dv/lpd_result_checker.sv
// Watches the byte and result channels of the deframer, tracks its frame
// state and register settings, and compares every result item with the
// oldest one still due.
module lpd_result_checker
	import lpd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   byte_valid,
	input  wire logic                   byte_stall,
	input  wire logic [7:0]             byte_in,
	input  wire logic                   result_valid,
	input  wire logic                   result_stall,
	input  wire logic [2:0]             kind,
	input  wire logic [7:0]             data_byte,
	input  wire logic                   wr_en,
	input  wire logic [CFG_INDEX_W-1:0] wr_index,
	input  wire logic [CFG_DATA_W-1:0]  wr_data,
	output int unsigned                 mismatches,
	output int unsigned                 outstanding
);

	typedef enum logic [1:0] {
		ST_HEADER  = 2'd0,
		ST_PAYLOAD = 2'd1,
		ST_SKIP    = 2'd2,
		ST_DEAD    = 2'd3
	} frame_state_t;

	// register copies
	logic [7:0]  magic_first_q;
	logic [7:0]  magic_second_q;
	logic [31:0] max_payload_q;

	// frame state
	frame_state_t frame_state;
	logic [2:0]   hdr_taken;
	logic [15:0]  magic_rx;
	logic [31:0]  len_acc;
	logic [31:0]  bytes_left;
	logic         zero_hit;

	item_t due_results[$];

	// Advance the frame state by one stream byte; queue the result it causes.
	task automatic deframe_byte(input logic [7:0] b);
		item_t r;
		r.kind = KIND_BYTE;
		r.data_byte = 8'h00;
		case (frame_state)
			ST_HEADER: begin
				if (hdr_taken < 3'd2)
					magic_rx = {magic_rx[7:0], b};
				else
					len_acc = {len_acc[23:0], b};
				hdr_taken = hdr_taken + 3'd1;
				if (hdr_taken == 3'd6) begin
					hdr_taken = 3'd0;
					if (magic_rx != {magic_first_q, magic_second_q}) begin
						frame_state = ST_DEAD;
						r.kind = KIND_PROTO;
						due_results.push_back(r);
					end else begin
						bytes_left = len_acc;
						len_acc = '0;
						magic_rx = '0;
						zero_hit = 1'b0;
						if (bytes_left >= max_payload_q) begin
							frame_state = (bytes_left != 0) ? ST_SKIP : ST_HEADER;
							r.kind = KIND_OVER;
							due_results.push_back(r);
						end else if (bytes_left == 0) begin
							r.kind = KIND_EMPTY;
							due_results.push_back(r);
						end else begin
							frame_state = ST_PAYLOAD;
						end
					end
				end
			end
			ST_SKIP: begin
				if (bytes_left != 0)
					bytes_left = bytes_left - 1;
				if (bytes_left == 0)
					frame_state = ST_HEADER;
			end
			ST_PAYLOAD: begin
				if (b == 8'h00)
					zero_hit = 1'b1;
				if (bytes_left != 0)
					bytes_left = bytes_left - 1;
				r.data_byte = b;
				if (bytes_left == 0) begin
					frame_state = ST_HEADER;
					r.kind = zero_hit ? KIND_ZERO : KIND_GOOD;
					zero_hit = 1'b0;
				end
				due_results.push_back(r);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t want;
		int unsigned bad;
		if (!arst_n) begin
			magic_first_q = 8'h00;
			magic_second_q = 8'h00;
			max_payload_q = MAX_PAYLOAD_RESET;
			frame_state = ST_HEADER;
			hdr_taken = 3'd0;
			magic_rx = '0;
			len_acc = '0;
			bytes_left = '0;
			zero_hit = 1'b0;
			due_results.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;
			// compare the accepted result with the oldest one due
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual kind %0d data %02h",
						$time, kind, data_byte);
					bad++;
				end else begin
					want = due_results.pop_front();
					if (kind !== want.kind) begin
						$display("%0t: kind mismatch, expected %0d, actual %0d",
							$time, want.kind, kind);
						bad++;
					end
					if (data_byte !== want.data_byte) begin
						$display("%0t: data_byte mismatch, expected %02h, actual %02h",
							$time, want.data_byte, data_byte);
						bad++;
					end
				end
			end
			if (byte_valid && !byte_stall)
				deframe_byte(byte_in);
			// track register writes
			if (wr_en) begin
				case (wr_index)
					CFG_MAGIC_FIRST:  magic_first_q = wr_data[7:0];
					CFG_MAGIC_SECOND: magic_second_q = wr_data[7:0];
					CFG_MAX_PAYLOAD:  max_payload_q = wr_data;
					default: ;
				endcase
			end
			mismatches <= mismatches + bad;
			outstanding <= due_results.size();
		end
	end

endmodule

FILE: dv/tb_length_prefixed_deframer.sv
module tb_length_prefixed_deframer;
	import lpd_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 300000;
	localparam int unsigned LONG_HOLD     = 80;
	localparam int unsigned SETTLE_CYCLES = 4;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   byte_valid = 1'b0;
	logic [7:0]             byte_in = 8'h00;
	logic                   result_stall = 1'b0;
	logic                   wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] wr_index = CFG_MAGIC_FIRST;
	logic [CFG_DATA_W-1:0]  wr_data = '0;
	wire                    byte_stall;
	wire                    result_valid;
	wire [2:0]              kind;
	wire [7:0]              data_byte;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycles = 0;
	int unsigned bytes_sent = 0;
	int unsigned hold_left = 0;
	bit          hold_taken = 1'b0;
	bit          hold_req = 1'b0;
	bit          quiet = 1'b0;

	// settings in force, for frame generation
	logic [7:0]  cur_magic_first = 8'h00;
	logic [7:0]  cur_magic_second = 8'h00;
	logic [31:0] cur_max = MAX_PAYLOAD_RESET;

	length_prefixed_deframer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_in      (byte_in),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	lpd_result_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_in      (byte_in),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("length_prefixed_deframer regression: fail");
			$finish;
		end
	end

	// Stall the result side at random; hold off once for a long stretch.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= LONG_HOLD;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !quiet && ($urandom_range(0, 99) < 9);
		end
	end

	// Offer one item and hold it until accepted.
	task automatic send_byte(input logic [7:0] b);
		if (!quiet && $urandom_range(0, 99) < 9) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_in <= b;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_header(input logic [7:0] m1, input logic [7:0] m2,
		input logic [31:0] len);
		send_byte(m1);
		send_byte(m2);
		send_byte(len[31:24]);
		send_byte(len[23:16]);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
	endtask

	// Bias payload toward zero and all-ones bytes.
	function automatic logic [7:0] payload_byte();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_frame(input logic [31:0] len);
		int unsigned i;
		send_header(cur_magic_first, cur_magic_second, len);
		for (i = 0; i < len; i++)
			send_byte(payload_byte());
	endtask

	// Drop valid and wait until every due result has come back.
	task automatic wait_drained();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three registers; call only while drained.
	task automatic set_config(input logic [7:0] mf, input logic [7:0] ms,
		input logic [31:0] mp);
		wr_en <= 1'b1;
		wr_index <= CFG_MAGIC_FIRST;
		wr_data <= CFG_DATA_W'(mf);
		@(posedge clk);
		wr_index <= CFG_MAGIC_SECOND;
		wr_data <= CFG_DATA_W'(ms);
		@(posedge clk);
		wr_index <= CFG_MAX_PAYLOAD;
		wr_data <= mp;
		@(posedge clk);
		wr_en <= 1'b0;
		cur_magic_first = mf;
		cur_magic_second = ms;
		cur_max = mp;
	endtask

	// Well-formed frames with random lengths, hitting the oversize boundary often when the limit is at most 64.
	task automatic random_frames(input int unsigned target);
		int unsigned start;
		int unsigned pick;
		logic [31:0] len;
		start = bytes_sent;
		while (bytes_sent - start < target) begin
			pick = $urandom_range(0, 9);
			if (cur_max <= 64) begin
				if (pick == 0)
					len = cur_max;
				else if (pick == 1)
					len = cur_max - 1;
				else
					len = $urandom_range(0, cur_max + 8);
			end else begin
				len = (pick == 0) ? 32'd0 : 32'($urandom_range(1, 24));
			end
			send_frame(len);
		end
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty message, good last byte, zero seen
		send_header(8'h00, 8'h00, 32'd0);
		send_header(8'h00, 8'h00, 32'd1);
		send_byte(8'hFF);
		send_header(8'h00, 8'h00, 32'd2);
		send_byte(8'h00);
		send_byte(8'h80);
		wait_drained();

		set_config(8'hA5, 8'h5A, 32'd16);
		random_frames(350);

		// long receiver hold while the sender keeps offering
		quiet <= 1'b1;
		set_config(8'hFF, 8'hFF, 32'hFFFF_FFFF);
		hold_req <= 1'b1;
		send_frame(32'd40);
		quiet <= 1'b0;
		random_frames(300);

		// stretch with no idling on either side, smallest limit
		quiet <= 1'b1;
		set_config(8'h00, 8'hFF, 32'd1);
		random_frames(300);
		quiet <= 1'b0;

		set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			32'($urandom_range(2, 64)));
		random_frames(350);

		set_config(8'h3C, 8'h00, MAX_PAYLOAD_RESET);
		random_frames(300);

		// bad second magic byte, then the block ignores everything
		send_header(8'h3C, 8'h01, 32'd5);
		repeat (30) send_byte(8'($urandom_range(0, 255)));
		wait_drained();

		if (mismatches == 0)
			$display("length_prefixed_deframer regression: pass");
		else
			$display("length_prefixed_deframer regression: fail");
		$finish;
	end

endmodule
